>>> sv/qps_pkg.sv
// Shared types and constants for the quadrature position and speed block.
// Used by every module of the block; depends on nothing else.
package qps_pkg;

   localparam int POS_W   = 32;
   localparam int TIME_W  = 32;
   localparam int SPEED_W = 40;
   localparam int PPR_W   = 16;
   // Divisor width: time difference times pulses per revolution.
   localparam int DEN_W   = TIME_W + PPR_W;

   localparam logic [PPR_W-1:0] PPR_RESET = 16'd1024;
   localparam int PPS_SCALE = 1000;
   localparam int RPM_SCALE = 60000;

   localparam logic [SPEED_W-1:0] SPEED_POS_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = {1'b1, {(SPEED_W-1){1'b0}}};

   localparam logic FUNC_PIN   = 1'b0;
   localparam logic FUNC_SPEED = 1'b1;

   typedef struct packed {
      logic              func;
      logic              pin_a;
      logic              pin_b;
      logic [TIME_W-1:0] time_ms;
   } qps_item_type;

   typedef struct packed {
      logic valid;
      logic pop;
   } qps_queue_ctl_type;

endpackage

>>> sv/qps_front.sv
// Input side: accepts request transfers and holds them in a two-entry queue.
// Depends on qps_pkg.
module qps_front import qps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // pin_a, pin_b, time_ms[31:0], zero pad
   input  logic         req_tuser,   // func
   output qps_item_type item,
   input  qps_queue_ctl_type queue_ctl_in,
   output logic         item_valid
);

   qps_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push;
   qps_item_type new_item;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (fill_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.func    = req_tuser;
      new_item.pin_a   = req_tdata[0];
      new_item.pin_b   = req_tdata[1];
      new_item.time_ms = req_tdata[TIME_W+1:2];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = queue_ctl_in.pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !queue_ctl_in.pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && queue_ctl_in.pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> sv/qps_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detection.
// Depends on qps_pkg only through the importing convention.
module qps_div import qps_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DIV_W = 48,
   parameter int QUO_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic             over,
   output logic [QUO_W-1:0] quo
);

   localparam int CMP_W = (NUM_W > DIV_W) ? NUM_W : DIV_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] lo_ff, lo_in;
   logic             over_ff, over_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [NUM_W+QUO_W-1:0] num_ext;
   logic [CMP_W-1:0]       hi_c;
   logic [CMP_W-1:0]       den_c;
   logic [DIV_W:0]         trial;
   logic                   ge;

   assign done = done_ff;
   assign over = over_ff;
   assign quo  = lo_ff;

   always_comb begin
      num_ext = {{QUO_W{1'b0}}, num};
      hi_c    = CMP_W'(num_ext[NUM_W+QUO_W-1:QUO_W]);
      den_c   = CMP_W'(den);
      trial   = {rem_ff, lo_ff[QUO_W-1]};
      ge      = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      over_in = over_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         // The quotient fits in QUO_W bits only if the high part is below the divisor.
         over_in = (hi_c >= den_c);
         rem_in  = hi_c[DIV_W-1:0];
         lo_in   = num_ext[QUO_W-1:0];
         den_in  = den;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         lo_in  = {lo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lo_ff   <= lo_in;
      over_ff <= over_in;
   end

endmodule

>>> sv/qps_back.sv
// Execution side: position counting, speed computation and the result register.
// Depends on qps_pkg and instantiates qps_div twice.
module qps_back import qps_pkg::*; #(
   parameter int COUNT_WIDTH = 32,
   parameter int FRAC_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  qps_item_type       item,
   input  logic               item_valid,
   output qps_queue_ctl_type  queue_ctl,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [PPR_W-1:0]   csr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [111:0]       rsp_tdata
);

   localparam int NUM_W = COUNT_WIDTH + 16 + FRAC_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [PPR_W-1:0]       ppr_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   prev_a_ff, prev_a_in;
   logic [COUNT_WIDTH-1:0] count_last_ff, count_last_in;
   logic [TIME_W-1:0]      time_last_ff, time_last_in;
   logic [SPEED_W-1:0]     pps_ff, pps_in;
   logic [SPEED_W-1:0]     rpm_ff, rpm_in;
   logic [COUNT_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [TIME_W-1:0]      dt_ff, dt_in;
   logic [TIME_W-1:0]      tm_ff, tm_in;
   logic                   out_valid_ff, out_valid_in;
   logic [111:0]           out_data_ff, out_data_in;

   logic                   pop;
   logic                   load;
   logic [TIME_W-1:0]      dt;
   logic [COUNT_WIDTH-1:0] diff;
   logic [PPR_W-1:0]       ppr_eff;
   logic                   div_start;
   logic [NUM_W-1:0]       pnum, rnum;
   logic [DEN_W-1:0]       pden, rden;
   logic                   pps_done, rpm_done;
   logic                   pps_over, rpm_over;
   logic [SPEED_W-1:0]     pps_quo, rpm_quo;

   // Magnitude and sign to a saturated two's complement speed.
   function automatic logic [SPEED_W-1:0] sat_speed(input logic over_flag,
                                                    input logic [SPEED_W-1:0] q,
                                                    input logic neg);
      logic [SPEED_W-1:0] m;
      if (neg) begin
         m = (over_flag || q > SPEED_NEG_MAG) ? SPEED_NEG_MAG : q;
         m = ~m + SPEED_W'(1);
      end else begin
         m = (over_flag || q > SPEED_POS_MAX) ? SPEED_POS_MAX : q;
      end
      return m;
   endfunction

   assign csr_ready       = 1'b1;
   assign pop             = item_valid && (state_ff == S_IDLE) && (!out_valid_ff || rsp_tready);
   assign queue_ctl.valid = item_valid;
   assign queue_ctl.pop   = pop;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;

   assign ppr_eff   = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign dt        = item.time_ms - time_last_ff;
   assign diff      = count_ff - count_last_ff;
   assign div_start = (state_ff == S_MUL);

   always_comb begin
      pnum = (NUM_W'(mag_ff) * NUM_W'(PPS_SCALE)) << FRAC_BITS;
      rnum = (NUM_W'(mag_ff) * NUM_W'(RPM_SCALE)) << FRAC_BITS;
      pden = DEN_W'(dt_ff);
      rden = DEN_W'(dt_ff) * DEN_W'(ppr_eff);
   end

   qps_div #(.NUM_W(NUM_W), .DIV_W(DEN_W), .QUO_W(SPEED_W)) u_pps_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (pnum),
      .den   (pden),
      .done  (pps_done),
      .over  (pps_over),
      .quo   (pps_quo)
   );

   qps_div #(.NUM_W(NUM_W), .DIV_W(DEN_W), .QUO_W(SPEED_W)) u_rpm_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rnum),
      .den   (rden),
      .done  (rpm_done),
      .over  (rpm_over),
      .quo   (rpm_quo)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      prev_a_in     = prev_a_ff;
      count_last_in = count_last_ff;
      time_last_in  = time_last_ff;
      pps_in        = pps_ff;
      rpm_in        = rpm_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      dt_in         = dt_ff;
      tm_in         = tm_ff;
      load          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               if (item.func == FUNC_PIN) begin
                  if (item.pin_a != prev_a_ff) begin
                     count_in = (item.pin_b != item.pin_a) ? count_ff + COUNT_WIDTH'(1)
                                                           : count_ff - COUNT_WIDTH'(1);
                  end
                  prev_a_in = item.pin_a;
                  load      = 1'b1;
               end else if (dt == '0) begin
                  load = 1'b1;
               end else begin
                  neg_in   = diff[COUNT_WIDTH-1];
                  mag_in   = diff[COUNT_WIDTH-1] ? ~diff + COUNT_WIDTH'(1) : diff;
                  dt_in    = dt;
                  tm_in    = item.time_ms;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (pps_done && rpm_done) begin
               pps_in        = sat_speed(pps_over, pps_quo, neg_ff);
               rpm_in        = sat_speed(rpm_over, rpm_quo, neg_ff);
               count_last_in = count_ff;
               time_last_in  = tm_ff;
               load          = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_data_in  = {rpm_in, pps_in, POS_W'($signed(count_in))};
      out_valid_in = load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ppr_ff        <= PPR_RESET;
         count_ff      <= '0;
         prev_a_ff     <= 1'b0;
         count_last_ff <= '0;
         time_last_ff  <= '0;
         pps_ff        <= '0;
         rpm_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid && csr_ready) begin
            ppr_ff <= csr_data;
         end
         count_ff      <= count_in;
         prev_a_ff     <= prev_a_in;
         count_last_ff <= count_last_in;
         time_last_ff  <= time_last_in;
         pps_ff        <= pps_in;
         rpm_ff        <= rpm_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      dt_ff  <= dt_in;
      tm_ff  <= tm_in;
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

>>> sv/quadrature_position_speed.sv
// Quadrature encoder position counter with pulses-per-second and rpm estimate.
// Depends on qps_pkg, qps_front, qps_back and qps_div.
//
// Usage: the req channel carries either a pin sample (tuser low, A and B levels)
// or a speed update (tuser high, millisecond timestamp). Every request transfer
// yields exactly one rsp transfer with the count and the last pps and rpm values,
// signed with FRAC_BITS fraction bits. csr_data writes pulses per revolution;
// write it only while no request is outstanding.
// Requests enter a two-entry queue, so the sender keeps going while results wait.
// A pin sample's result is held in the queue slot, then in the result register, and
// can then transfer on rsp; pin samples flow at one per cycle while rsp is not stalled
// and no speed update is in progress. A speed update with a nonzero time difference
// passes from request to result through the queue, setup, multiplication, the
// bit-serial dividers, which produce one quotient bit per cycle each, and the load of
// the result; the back end takes no new request until that result is loaded. A zero
// time difference is reported like a pin sample.
// Reset empties the queue and the result register, clears count, time and speed,
// and sets pulses per revolution to 1024. A stalled rsp holds its result; the
// back end stops taking items from the queue and req_tready falls once it fills.
module quadrature_position_speed import qps_pkg::*; #(
   parameter int COUNT_WIDTH = 32,
   parameter int FRAC_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,  // pin_a, pin_b, time_ms[31:0], zero pad
   input  logic               req_tuser,  // func
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [111:0]       rsp_tdata,  // position_count[31:0], pulses_per_sec[39:0],
                                          // revs_per_min[39:0]
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [PPR_W-1:0]   csr_data
);

   qps_item_type      item;
   logic              item_valid;
   qps_queue_ctl_type queue_ctl;

   qps_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .item         (item),
      .queue_ctl_in (queue_ctl),
      .item_valid   (item_valid)
   );

   qps_back #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .queue_ctl  (queue_ctl),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
